// File: sv/zcfpam_pkg.sv
// ----------------------------------------------------------------------------
// zcfpam_pkg
// Shared types and constants for the zero-crossing frequency and
// peak-to-peak amplitude meter.
// ----------------------------------------------------------------------------
`default_nettype none

package zcfpam_pkg;

    // Field widths.
    localparam int SAMPLE_W = 8;
    localparam int WORD_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDLINE        = 2'd2;

    // Reset values of registers and state.
    localparam logic [WORD_W-1:0]   RST_WINDOW_LENGTH  = 16'd250;
    localparam logic [WORD_W-1:0]   RST_RATE_NUMERATOR = 16'd1000;
    localparam logic [SAMPLE_W-1:0] RST_MIDLINE        = 8'd128;
    localparam logic [WORD_W-1:0]   RST_FREQUENCY      = 16'd100;
    localparam logic [SAMPLE_W-1:0] MIN_CLEAR          = 8'd255;
    localparam logic [SAMPLE_W-1:0] MAX_CLEAR          = 8'd0;
    localparam logic [WORD_W-1:0]   COUNT_MAX          = 16'hFFFF;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Serial divider: one quotient bit per cycle.
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // One classified sample, as handed from front to back.
    typedef struct packed {
        logic                freq_update;
        logic [WORD_W-1:0]   numerator;
        logic [WORD_W-1:0]   divisor;
        logic [SAMPLE_W-1:0] amplitude;
        logic                amp_update;
    } t_request;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_back_state;

endpackage

`default_nettype wire

// File: sv/zcfpam_front.sv
// ----------------------------------------------------------------------------
// zcfpam_front
// Holds the configuration registers and the per-sample state. Classifies each
// sample (crossing, window close) and emits one request per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module zcfpam_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [zcfpam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [zcfpam_pkg::WORD_W-1:0]      i_cfg_wdata,
    input  wire logic                               i_accept,
    input  wire logic [zcfpam_pkg::SAMPLE_W-1:0]    i_sample,
    output zcfpam_pkg::t_request                    o_request
);

    logic [zcfpam_pkg::WORD_W-1:0]   r_window_length;
    logic [zcfpam_pkg::WORD_W-1:0]   r_rate_numerator;
    logic [zcfpam_pkg::SAMPLE_W-1:0] r_midline;

    logic [zcfpam_pkg::SAMPLE_W-1:0] r_prev, n_prev;
    logic [zcfpam_pkg::WORD_W-1:0]   r_window_count, n_window_count;
    logic [zcfpam_pkg::WORD_W-1:0]   r_period_count, n_period_count;
    logic                            r_armed, n_armed;
    logic [zcfpam_pkg::SAMPLE_W-1:0] r_max, n_max;
    logic [zcfpam_pkg::SAMPLE_W-1:0] r_min, n_min;
    logic [zcfpam_pkg::SAMPLE_W-1:0] r_amplitude, n_amplitude;

    logic [zcfpam_pkg::WORD_W-1:0]   wc_inc;
    logic [zcfpam_pkg::WORD_W-1:0]   pc_inc;
    logic [zcfpam_pkg::SAMPLE_W-1:0] upd_max;
    logic [zcfpam_pkg::SAMPLE_W-1:0] upd_min;
    logic                            crossed;
    logic                            freq_update;
    logic                            window_close;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length  <= zcfpam_pkg::RST_WINDOW_LENGTH;
            r_rate_numerator <= zcfpam_pkg::RST_RATE_NUMERATOR;
            r_midline        <= zcfpam_pkg::RST_MIDLINE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                zcfpam_pkg::CFG_WINDOW_LENGTH:  r_window_length  <= i_cfg_wdata;
                zcfpam_pkg::CFG_RATE_NUMERATOR: r_rate_numerator <= i_cfg_wdata;
                zcfpam_pkg::CFG_MIDLINE:
                    r_midline <= i_cfg_wdata[zcfpam_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Classification of the incoming sample.
    always_comb begin
        wc_inc = (r_window_count == zcfpam_pkg::COUNT_MAX) ? zcfpam_pkg::COUNT_MAX
                                                           : r_window_count + 16'd1;
        pc_inc = (r_period_count == zcfpam_pkg::COUNT_MAX) ? zcfpam_pkg::COUNT_MAX
                                                           : r_period_count + 16'd1;
        crossed = ((r_prev < r_midline) && (i_sample >= r_midline)) ||
                  ((r_prev > r_midline) && (i_sample <= r_midline));
        freq_update  = crossed && r_armed;
        upd_max      = (i_sample > r_max) ? i_sample : r_max;
        upd_min      = (i_sample < r_min) ? i_sample : r_min;
        window_close = (wc_inc >= r_window_length);
    end

    // Next state of the per-sample registers.
    always_comb begin
        n_prev         = i_sample;
        n_window_count = window_close ? '0 : wc_inc;
        n_period_count = freq_update ? '0 : pc_inc;
        n_armed        = crossed ? !r_armed : r_armed;
        n_max          = window_close ? zcfpam_pkg::MAX_CLEAR : upd_max;
        n_min          = window_close ? zcfpam_pkg::MIN_CLEAR : upd_min;
        n_amplitude    = window_close ? (upd_max - upd_min) : r_amplitude;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev         <= '0;
            r_window_count <= '0;
            r_period_count <= '0;
            r_armed        <= 1'b0;
            r_max          <= zcfpam_pkg::MAX_CLEAR;
            r_min          <= zcfpam_pkg::MIN_CLEAR;
            r_amplitude    <= '0;
        end else if (i_accept) begin
            r_prev         <= n_prev;
            r_window_count <= n_window_count;
            r_period_count <= n_period_count;
            r_armed        <= n_armed;
            r_max          <= n_max;
            r_min          <= n_min;
            r_amplitude    <= n_amplitude;
        end
    end

    // Request toward the back end.
    always_comb begin
        o_request.freq_update = freq_update;
        o_request.numerator   = r_rate_numerator;
        o_request.divisor     = pc_inc;
        o_request.amplitude   = n_amplitude;
        o_request.amp_update  = window_close;
    end

endmodule

`default_nettype wire

// File: sv/zcfpam_queue.sv
// ----------------------------------------------------------------------------
// zcfpam_queue
// Small first-in first-out queue of requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module zcfpam_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire zcfpam_pkg::t_request   i_data,
    output logic                        o_full,
    input  wire logic                   i_pop,
    output zcfpam_pkg::t_request        o_data,
    output logic                        o_empty
);

    zcfpam_pkg::t_request r_mem [zcfpam_pkg::QUEUE_DEPTH];

    logic [zcfpam_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [zcfpam_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [zcfpam_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (zcfpam_pkg::QUEUE_AW+1)'(zcfpam_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The producers must respect full and empty.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

endmodule

`default_nettype wire

// File: sv/zcfpam_back.sv
// ----------------------------------------------------------------------------
// zcfpam_back
// Takes requests from the queue, runs the serial frequency divide when a
// request asks for it, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zcfpam_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire zcfpam_pkg::t_request               i_request,
    input  wire logic                               i_empty,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [zcfpam_pkg::WORD_W-1:0]           o_frequency,
    output logic [zcfpam_pkg::SAMPLE_W-1:0]         o_amplitude,
    output logic                                    o_frequency_updated,
    output logic                                    o_amplitude_updated
);

    zcfpam_pkg::t_back_state r_state, n_state;

    zcfpam_pkg::t_request                r_req;
    logic [zcfpam_pkg::WORD_W-1:0]       r_freq;
    logic [zcfpam_pkg::WORD_W-1:0]       r_quo, n_quo;
    logic [zcfpam_pkg::WORD_W-1:0]       r_rem, n_rem;
    logic [zcfpam_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [zcfpam_pkg::WORD_W:0]         trial;
    logic                                ge;
    logic                                last_step;

    logic                                r_valid;
    logic [zcfpam_pkg::WORD_W-1:0]       r_o_freq;
    logic [zcfpam_pkg::SAMPLE_W-1:0]     r_o_amp;
    logic                                r_o_fupd;
    logic                                r_o_aupd;

    logic                                out_free;
    logic                                load_plain;
    logic                                load_div;
    logic                                start_div;

    assign out_free  = !r_valid || !i_stall;
    assign last_step = (r_cnt == zcfpam_pkg::DIV_CNT_W'(zcfpam_pkg::DIV_STEPS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            zcfpam_pkg::ST_IDLE: begin
                if (!i_empty && out_free && i_request.freq_update) begin
                    n_state = zcfpam_pkg::ST_DIV;
                end
            end
            zcfpam_pkg::ST_DIV: begin
                if (last_step) begin
                    n_state = zcfpam_pkg::ST_DONE;
                end
            end
            zcfpam_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = zcfpam_pkg::ST_IDLE;
                end
            end
            default: n_state = zcfpam_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_pop      = 1'b0;
        load_plain = 1'b0;
        load_div   = 1'b0;
        start_div  = 1'b0;
        case (r_state)
            zcfpam_pkg::ST_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop      = 1'b1;
                    start_div  = i_request.freq_update;
                    load_plain = !i_request.freq_update;
                end
            end
            zcfpam_pkg::ST_DONE: begin
                load_div = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zcfpam_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // One restoring divide step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_quo[zcfpam_pkg::WORD_W-1]};
        ge    = (trial >= {1'b0, r_req.divisor});
        n_rem = ge ? zcfpam_pkg::WORD_W'(trial - {1'b0, r_req.divisor})
                   : trial[zcfpam_pkg::WORD_W-1:0];
        n_quo = {r_quo[zcfpam_pkg::WORD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_req <= i_request;
            r_quo <= i_request.numerator;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == zcfpam_pkg::ST_DIV) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Latest frequency, replaced when a divide finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= zcfpam_pkg::RST_FREQUENCY;
        end else if (load_div) begin
            r_freq <= r_quo;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_plain || load_div) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_plain) begin
            r_o_freq <= r_freq;
            r_o_amp  <= i_request.amplitude;
            r_o_fupd <= 1'b0;
            r_o_aupd <= i_request.amp_update;
        end else if (load_div) begin
            r_o_freq <= r_quo;
            r_o_amp  <= r_req.amplitude;
            r_o_fupd <= 1'b1;
            r_o_aupd <= r_req.amp_update;
        end
    end

    assign o_valid             = r_valid;
    assign o_frequency         = r_o_freq;
    assign o_amplitude         = r_o_amp;
    assign o_frequency_updated = r_o_fupd;
    assign o_amplitude_updated = r_o_aupd;

    // The divide never stalls on its way to the done state.
    a_div_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == zcfpam_pkg::ST_DIV && !last_step |=> r_state == zcfpam_pkg::ST_DIV)
        else $error("divide left early");

    // A finished divide leaves a remainder below the divisor.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == zcfpam_pkg::ST_DONE |-> r_rem < r_req.divisor)
        else $error("divide remainder out of range");

    // A frequency update only reaches the output from a finished divide.
    a_fupd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) && r_o_fupd |-> $past(r_state) == zcfpam_pkg::ST_DONE)
        else $error("frequency flag without a divide");

endmodule

`default_nettype wire

// File: sv/zero_cross_freq_peak_amp_meter_unit.sv
// ----------------------------------------------------------------------------
// zero_cross_freq_peak_amp_meter_unit
// Zero-crossing frequency and peak-to-peak amplitude meter: one result per
// sample, frequency by serial divide on every second midline crossing.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Payload
//  sample    in         i_in_valid / o_in_stall       i_sample
//  result    out        o_out_valid / i_out_stall     o_frequency, o_amplitude,
//                                                     o_frequency_updated,
//                                                     o_amplitude_updated
//  config    in         i_cfg_wr_en                   i_cfg_index, i_cfg_wdata
//
//  Samples without a frequency update pass at one item per cycle while the back end
//  is idle and the output is not stalled. A sample that updates the frequency is
//  loaded, run through the bit-serial restoring divider, and then handed off.
//  A four-entry request queue lets the front keep taking samples meanwhile.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A stalled output holds its register; the queue fills and then stalls input.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_cross_freq_peak_amp_meter_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [zcfpam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [zcfpam_pkg::WORD_W-1:0]      i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [zcfpam_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [zcfpam_pkg::WORD_W-1:0]           o_frequency,
    output logic [zcfpam_pkg::SAMPLE_W-1:0]         o_amplitude,
    output logic                                    o_frequency_updated,
    output logic                                    o_amplitude_updated
);

    zcfpam_pkg::t_request front_req;
    zcfpam_pkg::t_request queue_req;
    logic                 accept;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;

    // A request is accepted whenever the queue has room.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    zcfpam_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .o_request   (front_req)
    );

    zcfpam_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (queue_req),
        .o_empty (q_empty)
    );

    zcfpam_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_request           (queue_req),
        .i_empty             (q_empty),
        .o_pop               (q_pop),
        .o_valid             (o_out_valid),
        .i_stall             (i_out_stall),
        .o_frequency         (o_frequency),
        .o_amplitude         (o_amplitude),
        .o_frequency_updated (o_frequency_updated),
        .o_amplitude_updated (o_amplitude_updated)
    );

endmodule

`default_nettype wire
